### rtl/kuf_pkg.sv
// kuf_pkg: field widths, saturation limits and the tally interface types
// for the union-find edge filter. It depends on nothing; kuf_tally and the top level use it.
package kuf_pkg;

    localparam int ID_W      = 9;
    localparam int CFG_W     = 9;
    localparam int WGT_W     = 16;
    localparam int RANK_W    = 4;
    localparam int CNT_W     = 9;
    localparam int SUM_W     = 25;
    localparam int USED_W    = 8;
    localparam int OSUM_W    = 24;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;

    localparam logic [RANK_W-1:0] RANK_MAX   = 4'd15;
    localparam logic [CFG_W-1:0]  VCOUNT_RST = 9'd256;
    localparam logic [CNT_W-1:0]  USED_MAX   = 9'd255;
    localparam logic signed [SUM_W-1:0] OSUM_HI = 25'sd8388607;
    localparam logic signed [SUM_W-1:0] OSUM_LO = -25'sd8388608;

    typedef struct packed {
        logic                    clear;
        logic                    take;
        logic signed [WGT_W-1:0] weight;
    } tally_ctrl_t;

    typedef struct packed {
        logic [CNT_W-1:0]        count;
        logic signed [SUM_W-1:0] sum;
    } tally_stat_t;

endpackage

### rtl/kuf_ram.sv
// kuf_ram: single write port, single registered read port memory holding
// one forest entry (rank and parent) per vertex. Depends on nothing.
module kuf_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 12
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

### rtl/kuf_tally.sv
// kuf_tally: taken-edge count and running weight sum of the current graph.
// Depends on kuf_pkg for the control and status structs.
module kuf_tally (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  kuf_pkg::tally_ctrl_t ctrl,
    output kuf_pkg::tally_stat_t stat
);

    logic [kuf_pkg::CNT_W-1:0]        count_reg, count_next;
    logic signed [kuf_pkg::SUM_W-1:0] sum_reg, sum_next;

    always_comb begin
        count_next = count_reg;
        sum_next   = sum_reg;
        if (ctrl.clear) begin
            count_next = '0;
            sum_next   = '0;
        end else if (ctrl.take) begin
            count_next = count_reg + kuf_pkg::CNT_W'(1);
            sum_next   = sum_reg + kuf_pkg::SUM_W'(ctrl.weight);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            sum_reg   <= '0;
        end else begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

    assign stat.count = count_reg;
    assign stat.sum   = sum_reg;

endmodule

### rtl/kruskal_union_find_edge_filter.sv
// kruskal_union_find_edge_filter: top level, find/compress/union sequencer
// around the forest memory. Depends on kuf_pkg, kuf_ram and kuf_tally.
//
//  port group   dir  tdata (low bit up)                              tlast
//  s_*          in   edge_src[8:0] edge_dst[17:9] edge_weight[33:18]  last_edge
//  m_*          out  edge_taken[0] bad_vertex[1] tree_complete[2]    -
//                    edges_used[10:3] total_weight[34:11]
//  cfg_*        in   vertex_count[8:0]                               -
//
// An item that is bad or finds the tree complete goes straight to the result;
// otherwise both chains are walked up and compressed, then the roots are joined,
// with a rank write on a rank tie below the rank limit, all through the single memory port walked one link per cycle.
// Reset and every last_edge item start a sweep over all MAX_VERTICES entries
// that rewrites the forest; no item is taken meanwhile.
// The result register lets the next item run while a result waits.
module kruskal_union_find_edge_filter #(
    parameter int MAX_VERTICES = 256
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [kuf_pkg::IN_DATA_W-1:0]   s_tdata,  // edge_src, edge_dst, edge_weight
    input  logic                            s_tlast,  // last_edge
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [kuf_pkg::OUT_DATA_W-1:0]  m_tdata,  // edge_taken, bad_vertex,
                                                      // tree_complete, edges_used,
                                                      // total_weight
    input  logic                            cfg_we,
    input  logic [kuf_pkg::CFG_W-1:0]       cfg_wdata // vertex_count
);

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int DW = kuf_pkg::RANK_W + VW;
    localparam logic [VW-1:0] LAST_IDX = VW'(MAX_VERTICES - 1);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_LOAD, S_UP, S_CMP, S_UNION, S_RANK, S_DONE
    } state_t;

    state_t state_reg, state_next;

    logic [VW-1:0] clr_idx_reg, clr_idx_next;
    logic [VW-1:0] src_idx_reg, src_idx_next, dst_idx_reg, dst_idx_next;
    logic [VW-1:0] cur_reg, cur_next, ra_reg, ra_next, rb_reg, rb_next;
    logic [kuf_pkg::RANK_W-1:0] rank_a_reg, rank_a_next, rank_b_reg, rank_b_next;
    logic phase_reg, phase_next, bad_reg, bad_next, last_reg, last_next;
    logic taken_reg, taken_next;
    logic signed [kuf_pkg::WGT_W-1:0] weight_reg, weight_next;
    logic [kuf_pkg::CFG_W-1:0] n_reg, n_next, vcount_reg, vcount_next;
    logic m_valid_reg, m_valid_next;
    logic [kuf_pkg::OUT_DATA_W-1:0] m_data_reg, m_data_next;

    logic          wr_en;
    logic [VW-1:0] wr_addr, rd_addr;
    logic [DW-1:0] wr_data, rd_data;
    logic [VW-1:0] r_parent;
    logic [kuf_pkg::RANK_W-1:0] r_rank;

    kuf_pkg::tally_ctrl_t tally_ctrl;
    kuf_pkg::tally_stat_t tally_stat;

    logic [kuf_pkg::ID_W-1:0]  in_src, in_dst;
    logic [kuf_pkg::CFG_W-1:0] n_eff;
    logic                      in_bad, in_complete, out_complete;
    logic [VW-1:0]             start_idx, root_cur;
    logic [kuf_pkg::USED_W-1:0] out_used;
    logic [kuf_pkg::OSUM_W-1:0] out_sum;

    kuf_ram #(
        .DEPTH (MAX_VERTICES),
        .AW    (VW),
        .DW    (DW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    kuf_tally u_tally (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (tally_ctrl),
        .stat    (tally_stat)
    );

    assign r_parent = rd_data[VW-1:0];
    assign r_rank   = rd_data[DW-1:VW];
    assign in_src   = s_tdata[8:0];
    assign in_dst   = s_tdata[17:9];

    always_comb begin
        if (32'(vcount_reg) > MAX_VERTICES) begin
            n_eff = kuf_pkg::CFG_W'(MAX_VERTICES);
        end else begin
            n_eff = vcount_reg;
        end
    end

    assign in_bad = (in_src == '0) || (in_src > n_eff) || (in_dst == '0) || (in_dst > n_eff);
    assign in_complete = (n_eff <= kuf_pkg::CFG_W'(1)) ||
        (({1'b0, tally_stat.count} + 10'd1) >= {1'b0, n_eff});
    assign out_complete = (n_reg <= kuf_pkg::CFG_W'(1)) ||
        (({1'b0, tally_stat.count} + 10'd1) >= {1'b0, n_reg});

    assign start_idx = phase_reg ? dst_idx_reg : src_idx_reg;
    assign root_cur  = phase_reg ? rb_reg : ra_reg;

    always_comb begin
        if (tally_stat.count > kuf_pkg::USED_MAX) begin
            out_used = '1;
        end else begin
            out_used = tally_stat.count[kuf_pkg::USED_W-1:0];
        end
        if (tally_stat.sum > kuf_pkg::OSUM_HI) begin
            out_sum = kuf_pkg::OSUM_HI[kuf_pkg::OSUM_W-1:0];
        end else if (tally_stat.sum < kuf_pkg::OSUM_LO) begin
            out_sum = kuf_pkg::OSUM_LO[kuf_pkg::OSUM_W-1:0];
        end else begin
            out_sum = tally_stat.sum[kuf_pkg::OSUM_W-1:0];
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        src_idx_next = src_idx_reg;
        dst_idx_next = dst_idx_reg;
        cur_next     = cur_reg;
        ra_next      = ra_reg;
        rb_next      = rb_reg;
        rank_a_next  = rank_a_reg;
        rank_b_next  = rank_b_reg;
        phase_next   = phase_reg;
        bad_next     = bad_reg;
        last_next    = last_reg;
        taken_next   = taken_reg;
        weight_next  = weight_reg;
        n_next       = n_reg;
        vcount_next  = cfg_we ? cfg_wdata : vcount_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        rd_addr      = '0;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = '0;
        tally_ctrl.clear  = 1'b0;
        tally_ctrl.take   = 1'b0;
        tally_ctrl.weight = weight_reg;

        case (state_reg)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = clr_idx_reg;
                wr_data = {kuf_pkg::RANK_W'(0), clr_idx_reg};
                clr_idx_next = clr_idx_reg + VW'(1);
                if (clr_idx_reg == LAST_IDX) begin
                    clr_idx_next = '0;
                    state_next   = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    src_idx_next = VW'(in_src - kuf_pkg::ID_W'(1));
                    dst_idx_next = VW'(in_dst - kuf_pkg::ID_W'(1));
                    weight_next  = s_tdata[33:18];
                    last_next    = s_tlast;
                    bad_next     = in_bad;
                    n_next       = n_eff;
                    taken_next   = 1'b0;
                    phase_next   = 1'b0;
                    state_next   = (in_bad || in_complete) ? S_DONE : S_LOAD;
                end
            end
            S_LOAD: begin
                rd_addr    = start_idx;
                cur_next   = start_idx;
                state_next = S_UP;
            end
            S_UP: begin
                if (r_parent == cur_reg) begin
                    if (phase_reg) begin
                        rb_next     = cur_reg;
                        rank_b_next = r_rank;
                    end else begin
                        ra_next     = cur_reg;
                        rank_a_next = r_rank;
                    end
                    if (start_idx == cur_reg) begin
                        phase_next = 1'b1;
                        state_next = phase_reg ? S_UNION : S_LOAD;
                    end else begin
                        rd_addr    = start_idx;
                        cur_next   = start_idx;
                        state_next = S_CMP;
                    end
                end else begin
                    rd_addr  = r_parent;
                    cur_next = r_parent;
                end
            end
            S_CMP: begin
                wr_en   = 1'b1;
                wr_addr = cur_reg;
                wr_data = {r_rank, root_cur};
                if (r_parent == root_cur) begin
                    phase_next = 1'b1;
                    state_next = phase_reg ? S_UNION : S_LOAD;
                end else begin
                    rd_addr  = r_parent;
                    cur_next = r_parent;
                end
            end
            S_UNION: begin
                state_next = S_DONE;
                if (ra_reg != rb_reg) begin
                    taken_next      = 1'b1;
                    tally_ctrl.take = 1'b1;
                    wr_en           = 1'b1;
                    if (rank_a_reg < rank_b_reg) begin
                        wr_addr = ra_reg;
                        wr_data = {rank_a_reg, rb_reg};
                    end else begin
                        wr_addr = rb_reg;
                        wr_data = {rank_b_reg, ra_reg};
                        if (rank_a_reg == rank_b_reg && rank_a_reg != kuf_pkg::RANK_MAX) begin
                            state_next = S_RANK;
                        end
                    end
                end
            end
            S_RANK: begin
                wr_en      = 1'b1;
                wr_addr    = ra_reg;
                wr_data    = {rank_a_reg + kuf_pkg::RANK_W'(1), ra_reg};
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = kuf_pkg::OUT_DATA_W'({out_sum, out_used, out_complete,
                                                         bad_reg, taken_reg});
                    if (last_reg) begin
                        tally_ctrl.clear = 1'b1;
                        state_next       = S_CLEAR;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_idx_reg <= '0;
            phase_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
            vcount_reg  <= kuf_pkg::VCOUNT_RST;
        end else begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
            vcount_reg  <= vcount_next;
            src_idx_reg <= src_idx_next;
            dst_idx_reg <= dst_idx_next;
            cur_reg     <= cur_next;
            ra_reg      <= ra_next;
            rb_reg      <= rb_next;
            rank_a_reg  <= rank_a_next;
            rank_b_reg  <= rank_b_next;
            bad_reg     <= bad_next;
            last_reg    <= last_next;
            taken_reg   <= taken_next;
            weight_reg  <= weight_next;
            n_reg       <= n_next;
            m_data_reg  <= m_data_next;
        end
    end

    // compression rewrites one node while fetching its parent
    a_cmp_no_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CMP && r_parent != root_cur) |-> (wr_addr != rd_addr))
        else $error("compression write and read hit the same entry");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("new item taken while one is in work");

    a_taken_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && in_bad) |=> !taken_next)
        else $error("bad edge marked as taken");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        tally_ctrl.take |-> ({1'b0, tally_stat.count} + 10'd2 <= {1'b0, n_reg}))
        else $error("edge taken after the tree was complete");

endmodule
